FILE: rtl/tgarle_pkg.sv
// ----------------------------------------------------------------------------
// tgarle_pkg
// Shared types and constants of the TGA run-length pixel decoder.
// ----------------------------------------------------------------------------
package tgarle_pkg;

   localparam logic [7:0] RLE_FLAG = 8'h80;
   localparam logic [7:0] LEN_MASK = 8'h7f;

   localparam int unsigned CSR_ADDR_W = 3;
   localparam int unsigned CSR_DATA_W = 32;

   localparam logic REG_ALPHA_PRESENT = 1'b0;
   localparam logic REG_PIXEL_TOTAL   = 1'b1;

   localparam logic [1:0] COMP_BLUE  = 2'd0;
   localparam logic [1:0] COMP_GREEN = 2'd1;
   localparam logic [1:0] COMP_RED   = 2'd2;
   localparam logic [1:0] COMP_ALPHA = 2'd3;

   typedef struct packed {
      logic        alpha_present;
      logic [31:0] pixel_total;
   } cfg_type;

   typedef struct packed {
      logic [7:0] repeat_count;
      logic [7:0] alpha;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       last_of_image;
   } result_type;

endpackage

FILE: rtl/tgarle_decode.sv
// ----------------------------------------------------------------------------
// tgarle_decode
// Packet and pixel state of the decoder; decodes one stream byte per step.
// ----------------------------------------------------------------------------
module tgarle_decode (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step,
   input  logic [7:0]             data_byte,
   input  tgarle_pkg::cfg_type    cfg,
   output logic                   result_valid,
   output tgarle_pkg::result_type result
);
   import tgarle_pkg::*;

   logic        image_active_ff, image_active_in;
   logic [31:0] pixels_remaining_ff, pixels_remaining_in;
   logic        expect_header_ff, expect_header_in;
   logic        packet_is_run_ff, packet_is_run_in;
   logic [7:0]  packet_pixels_left_ff, packet_pixels_left_in;
   logic [1:0]  component_index_ff, component_index_in;
   logic [23:0] partial_pixel_ff, partial_pixel_in;

   logic [31:0] rem_base;
   logic [7:0]  hdr_len;
   logic [7:0]  ppl_next;
   logic [23:0] pixel;
   logic        accumulate;
   logic        last;

   always_comb begin
      image_active_in       = image_active_ff;
      pixels_remaining_in   = pixels_remaining_ff;
      expect_header_in      = expect_header_ff;
      packet_is_run_in      = packet_is_run_ff;
      packet_pixels_left_in = packet_pixels_left_ff;
      component_index_in    = component_index_ff;
      partial_pixel_in      = partial_pixel_ff;
      result_valid          = 1'b0;
      result                = '0;
      ppl_next              = 8'd0;
      pixel                 = partial_pixel_ff;
      last                  = 1'b0;

      rem_base   = image_active_ff ? pixels_remaining_ff : cfg.pixel_total;
      hdr_len    = (data_byte & LEN_MASK) + 8'd1;
      if ({24'd0, hdr_len} > rem_base) begin
         hdr_len = rem_base[7:0];
      end
      accumulate = (component_index_ff != COMP_ALPHA) &&
                   !(component_index_ff == COMP_RED && !cfg.alpha_present);

      if (!image_active_ff || expect_header_ff) begin
         if (image_active_ff || cfg.pixel_total != 32'd0) begin
            image_active_in       = 1'b1;
            pixels_remaining_in   = rem_base - {24'd0, hdr_len};
            packet_pixels_left_in = hdr_len;
            packet_is_run_in      = (data_byte & RLE_FLAG) != 8'd0;
            expect_header_in      = 1'b0;
            component_index_in    = COMP_BLUE;
            partial_pixel_in      = '0;
         end
      end else if (accumulate) begin
         unique case (component_index_ff)
            COMP_BLUE:  partial_pixel_in[7:0]   = data_byte;
            COMP_GREEN: partial_pixel_in[15:8]  = data_byte;
            default:    partial_pixel_in[23:16] = data_byte;
         endcase
         component_index_in = component_index_ff + 2'd1;
      end else begin
         if (component_index_ff == COMP_RED) begin
            pixel = {data_byte, partial_pixel_ff[15:0]};
         end
         if (packet_is_run_ff) begin
            result.repeat_count = packet_pixels_left_ff;
            ppl_next            = 8'd0;
         end else begin
            result.repeat_count = 8'd1;
            ppl_next = (packet_pixels_left_ff != 8'd0) ?
                       packet_pixels_left_ff - 8'd1 : 8'd0;
         end
         last                  = (ppl_next == 8'd0) && (pixels_remaining_ff == 32'd0);
         result_valid          = 1'b1;
         result.blue           = pixel[7:0];
         result.green          = pixel[15:8];
         result.red            = pixel[23:16];
         result.alpha          = (component_index_ff == COMP_ALPHA && cfg.alpha_present) ?
                                 data_byte : 8'd0;
         result.last_of_image  = last;
         packet_pixels_left_in = ppl_next;
         component_index_in    = COMP_BLUE;
         partial_pixel_in      = '0;
         if (ppl_next == 8'd0) begin
            expect_header_in = 1'b1;
            if (last) begin
               image_active_in = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         image_active_ff       <= 1'b0;
         pixels_remaining_ff   <= '0;
         expect_header_ff      <= 1'b1;
         packet_is_run_ff      <= 1'b0;
         packet_pixels_left_ff <= '0;
         component_index_ff    <= COMP_BLUE;
         partial_pixel_ff      <= '0;
      end else if (step) begin
         image_active_ff       <= image_active_in;
         pixels_remaining_ff   <= pixels_remaining_in;
         expect_header_ff      <= expect_header_in;
         packet_is_run_ff      <= packet_is_run_in;
         packet_pixels_left_ff <= packet_pixels_left_in;
         component_index_ff    <= component_index_in;
         partial_pixel_ff      <= partial_pixel_in;
      end
   end

endmodule

FILE: rtl/tga_rle_pixel_decoder_core.sv
// ----------------------------------------------------------------------------
// tga_rle_pixel_decoder_core
// TGA run-length pixel decoder with stream ports and a register port.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries the compressed stream, one byte per transfer. Packet
//   headers and pixel bytes (blue, green, red, optional alpha) share it.
//   rsp_* carries one decoded pixel per transfer with its repeat count;
//   rsp_tlast marks the pixels that complete the image.
//   csr_* sets alpha_present (address 0) and pixel_total (address 4);
//   write only while the block is idle.
//   Throughput is one byte per cycle while req_tready is high; each byte
//   is decoded in the cycle of its transfer and its result is registered
//   in the output register, or in the skid entry when that one is held.
//   A two-entry output stage (register plus skid) keeps req_tready high
//   while one result waits on a stalled receiver; req_tready drops only
//   when both entries are full.
//   Reset clears all decode state; the first byte after reset is a header.
// ----------------------------------------------------------------------------
module tga_rle_pixel_decoder_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [7:0]                         req_tdata,   // data_byte
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [39:0]                        rsp_tdata,   // blue, green, red,
                                                           // alpha, repeat_count
   output logic                               rsp_tlast,   // last_of_image
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [tgarle_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [tgarle_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [tgarle_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                               csr_pready
);
   import tgarle_pkg::*;

   cfg_type    cfg_ff;
   logic       csr_write;

   logic       req_accept;
   logic       dec_valid;
   result_type dec_result;

   logic       main_valid_ff, main_valid_in;
   result_type main_ff, main_in;
   logic       skid_valid_ff, skid_valid_in;
   result_type skid_ff, skid_in;
   logic       rsp_take;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_write) begin
         unique case (csr_paddr[2])
            REG_ALPHA_PRESENT: cfg_ff.alpha_present <= csr_pwdata[0];
            default:           cfg_ff.pixel_total   <= csr_pwdata[31:0];
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         REG_ALPHA_PRESENT: csr_prdata = {31'd0, cfg_ff.alpha_present};
         default:           csr_prdata = cfg_ff.pixel_total;
      endcase
   end

   assign req_tready = !skid_valid_ff;
   assign req_accept = req_tvalid && req_tready;

   tgarle_decode u_decode (
      .clock        (clock),
      .reset        (reset),
      .step         (req_accept),
      .data_byte    (req_tdata),
      .cfg          (cfg_ff),
      .result_valid (dec_valid),
      .result       (dec_result)
   );

   assign rsp_take = main_valid_ff && rsp_tready;

   always_comb begin
      main_valid_in = main_valid_ff;
      main_in       = main_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (skid_valid_ff) begin
         if (rsp_take) begin
            main_in       = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (req_accept && dec_valid) begin
         if (!main_valid_ff || rsp_take) begin
            main_in       = dec_result;
            main_valid_in = 1'b1;
         end else begin
            skid_in       = dec_result;
            skid_valid_in = 1'b1;
         end
      end else if (rsp_take) begin
         main_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   assign rsp_tvalid = main_valid_ff;
   assign rsp_tdata  = {main_ff.repeat_count, main_ff.alpha, main_ff.red,
                        main_ff.green, main_ff.blue};
   assign rsp_tlast  = main_ff.last_of_image;

   a_skid_needs_main: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> main_valid_ff)
      else $error("skid entry held without a main entry");

   a_skid_refills_main: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff && rsp_tready |=> main_valid_ff && !skid_valid_ff)
      else $error("skid entry lost on drain");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      main_valid_ff |-> (main_ff.repeat_count != 8'd0) &&
                        (main_ff.repeat_count <= 8'd128))
      else $error("repeat count out of range");

endmodule
